// ----- hdl/swarq_pkg.sv -----
// Shared types and constants for the sliding-window ARQ receiver.
// No dependencies; imported by the payload RAM and the top level.
`default_nettype none

package swarq_pkg;

    // result kind codes
    localparam logic RK_ACK  = 1'b0;
    localparam logic RK_DATA = 1'b1;

    // input item kind codes
    localparam logic IK_START = 1'b0;
    localparam logic IK_DATA  = 1'b1;

    // kind of the last completed transfer
    typedef enum logic [1:0] {
        CK_NONE = 2'd0,
        CK_GBN  = 2'd1,
        CK_SEL  = 2'd2
    } t_completed;

    // index width for a store of n entries, at least one bit
    function automatic int idx_bits(input int n);
        idx_bits = (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/swarq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on swarq_pkg for the address width helper.
`default_nettype none

module swarq_ram
    import swarq_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 5
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [idx_bits(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic [idx_bits(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/sliding_window_arq_receiver_top.sv -----
// Receiver side of a go-back-N / selective-repeat ARQ transfer.
// Depends on swarq_pkg and swarq_ram (payload slot store).
`default_nettype none

// A command is taken when i_start is high and o_busy is low. A start command
// is absorbed when it is taken and yields no result. A data packet holds o_busy
// high while it is evaluated and its results are made. In selective-repeat mode
// the evaluation state produces its acknowledgement, and the in-order release
// then drains the k buffered payloads it releases (0 to WINDOW), one payload
// slot per cycle, through the single read port of the payload RAM. In go-back-N
// mode a delivered packet yields two results (payload, then cumulative ack).
// Each result shows on the output ports for exactly one cycle with o_valid
// high; the consumer must take it then. The results of one packet come in
// consecutive cycles and the final one carries o_last. Received marks live in
// flip-flops and are cleared by the start command itself, so there is no
// clearing pass after reset.
module sliding_window_arq_receiver_top
    import swarq_pkg::*;
#(
    parameter int WINDOW       = 5,
    parameter int SEQ_SPACE    = 12,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic        i_kind,
    input  wire logic        i_use_selective,
    input  wire logic [15:0] i_packet_count,
    input  wire logic [3:0]  i_seq,
    input  wire logic [31:0] i_payload,
    output logic             o_valid,
    output logic             o_result_kind,
    output logic [3:0]       o_ack_seq,
    output logic [31:0]      o_delivered_payload,
    output logic [15:0]      o_delivered_index,
    output logic             o_transfer_done,
    output logic             o_last
);

    localparam int SLOT_W = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
    localparam int WB     = idx_bits(WINDOW);
    localparam int SW     = idx_bits(SEQ_SPACE);
    localparam int SUMW   = WB + 1;

    localparam logic [SUMW-1:0] WIN_S   = SUMW'(WINDOW);
    localparam logic [16:0]     WIN_17  = 17'(WINDOW);
    localparam logic [7:0]      WIN_8   = 8'(WINDOW);
    localparam logic [7:0]      SEQ_8   = 8'(SEQ_SPACE);
    localparam logic [SW-1:0]   SEQ_TOP = SW'(SEQ_SPACE - 1);
    localparam logic [WB-1:0]   WIN_TOP = WB'(WINDOW - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_GACK,
        S_DLV
    } t_state;

    t_state            r_state;
    logic              r_active;
    logic              r_sel;
    t_completed        r_completed;
    logic [SW-1:0]     r_expected;
    logic [15:0]       r_remaining;
    logic [15:0]       r_total;
    logic [15:0]       r_base;
    logic [WB-1:0]     r_base_slot;
    logic [SW-1:0]     r_base_seq;
    logic [WINDOW-1:0] r_marks;
    logic [3:0]        r_seq;
    logic [SLOT_W-1:0] r_pay;
    logic              r_fwd;

    logic [7:0]        seq_8;
    logic [7:0]        bseq_8;
    logic [7:0]        seq_offset;
    logic [15:0]       rem;
    logic              seq_ok;
    logic              found;
    logic [SUMW-1:0]   slot_sum;
    logic [WB-1:0]     slot;
    logic [WINDOW-1:0] new_marks;
    logic [WINDOW-1:0] covered;
    logic              done_sel;
    logic              base_marked;
    logic [WB-1:0]     next_slot;
    logic [SW-1:0]     base_seq_inc;
    logic [SW-1:0]     expected_inc;
    logic              more;
    logic              ram_we;
    logic [WB-1:0]     ram_raddr;
    logic [SLOT_W-1:0] ram_rdata;
    logic [SLOT_W-1:0] dlv_data;

    assign o_busy = (r_state != S_IDLE);

    // window lookup: offset of the packet from the window base
    always_comb begin
        seq_8  = {4'b0000, r_seq};
        bseq_8 = 8'(r_base_seq);
        seq_ok = (seq_8 < SEQ_8);
        if (seq_8 >= bseq_8) begin
            seq_offset = seq_8 - bseq_8;
        end else begin
            seq_offset = seq_8 + SEQ_8 - bseq_8;
        end
        rem   = r_total - r_base;
        found = (seq_offset < WIN_8) && (17'(seq_offset) < {1'b0, rem});
        slot_sum = {1'b0, r_base_slot} + SUMW'(seq_offset);
        if (slot_sum >= WIN_S) begin
            slot_sum = slot_sum - WIN_S;
        end
        slot = slot_sum[WB-1:0];
    end

    // marks after storing this packet, and whether the window then drains fully
    always_comb begin
        logic [SUMW-1:0] k_sum;
        new_marks = r_marks;
        if (found) begin
            new_marks[slot] = 1'b1;
        end
        for (int k = 0; k < WINDOW; k++) begin
            k_sum = {1'b0, r_base_slot} + SUMW'(k);
            if (k_sum >= WIN_S) begin
                k_sum = k_sum - WIN_S;
            end
            covered[k] = (17'(k) >= {1'b0, rem}) || new_marks[k_sum[WB-1:0]];
        end
        done_sel    = ({1'b0, rem} <= WIN_17) && (&covered);
        base_marked = new_marks[r_base_slot];
    end

    // ring and sequence increments
    always_comb begin
        next_slot    = (r_base_slot == WIN_TOP) ? '0 : r_base_slot + WB'(1);
        base_seq_inc = (r_base_seq == SEQ_TOP) ? '0 : r_base_seq + SW'(1);
        expected_inc = (r_expected == SEQ_TOP) ? '0 : r_expected + SW'(1);
        more = (({1'b0, r_base} + 17'd1) < {1'b0, r_total})
               && (next_slot != r_base_slot) && r_marks[next_slot];
    end

    // payload store access: write on a fresh in-window packet, read the drain slot
    assign ram_we    = (r_state == S_EVAL) && seq_ok && r_active && r_sel
                       && found && !r_marks[slot];
    assign ram_raddr = (r_state == S_DLV) ? next_slot : r_base_slot;
    assign dlv_data  = r_fwd ? r_pay : ram_rdata;

    swarq_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (WINDOW)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot),
        .i_wdata (r_pay),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // control state machine and registered result ports
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= 1'b0;
            r_sel       <= 1'b0;
            r_completed <= CK_NONE;
            r_expected  <= '0;
            r_remaining <= '0;
            r_total     <= '0;
            r_base      <= '0;
            r_base_slot <= '0;
            r_base_seq  <= '0;
            r_marks     <= '0;
            r_fwd       <= 1'b0;
            o_valid     <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (i_kind == IK_START) begin
                            r_sel       <= i_use_selective;
                            r_total     <= i_packet_count;
                            r_remaining <= i_packet_count;
                            r_expected  <= '0;
                            r_base      <= '0;
                            r_base_slot <= '0;
                            r_base_seq  <= '0;
                            r_marks     <= '0;
                            r_active    <= (i_packet_count != 16'd0);
                            if (i_packet_count == 16'd0) begin
                                r_completed <= i_use_selective ? CK_SEL : CK_GBN;
                            end
                        end else begin
                            r_seq   <= i_seq;
                            r_pay   <= i_payload[SLOT_W-1:0];
                            r_state <= S_EVAL;
                        end
                    end
                end
                S_EVAL: begin
                    r_state             <= S_IDLE;
                    o_result_kind       <= RK_ACK;
                    o_ack_seq           <= r_seq;
                    o_delivered_payload <= '0;
                    o_delivered_index   <= '0;
                    o_transfer_done     <= 1'b0;
                    o_last              <= 1'b1;
                    r_fwd               <= 1'b0;
                    if (!seq_ok) begin
                        // out-of-range sequence: silently dropped
                    end else if (!r_active) begin
                        // after completion only acks go out
                        o_transfer_done <= 1'b1;
                        if (r_completed == CK_GBN) begin
                            o_valid   <= 1'b1;
                            o_ack_seq <= 4'(r_expected);
                        end else if (r_completed == CK_SEL) begin
                            o_valid <= 1'b1;
                        end
                    end else if (!r_sel) begin
                        o_valid <= 1'b1;
                        if (seq_8 == 8'(r_expected)) begin
                            // in-order packet: deliver, then cumulative ack
                            o_result_kind       <= RK_DATA;
                            o_ack_seq           <= '0;
                            o_delivered_payload <= 32'(r_pay);
                            o_delivered_index   <= r_total - r_remaining;
                            o_transfer_done     <= (r_remaining == 16'd1);
                            o_last              <= 1'b0;
                            r_remaining         <= r_remaining - 16'd1;
                            r_expected          <= expected_inc;
                            if (r_remaining == 16'd1) begin
                                r_active    <= 1'b0;
                                r_completed <= CK_GBN;
                            end
                            r_state <= S_GACK;
                        end else begin
                            o_ack_seq <= 4'(r_expected);
                        end
                    end else begin
                        // selective repeat: ack own sequence, buffer, start drain
                        o_valid <= 1'b1;
                        if (found) begin
                            r_marks         <= new_marks;
                            o_transfer_done <= done_sel;
                            o_last          <= !base_marked;
                            r_fwd           <= ram_we && (slot == r_base_slot);
                            if (done_sel) begin
                                r_active    <= 1'b0;
                                r_completed <= CK_SEL;
                            end
                            if (base_marked) begin
                                r_state <= S_DLV;
                            end
                        end
                    end
                end
                S_GACK: begin
                    o_valid             <= 1'b1;
                    o_result_kind       <= RK_ACK;
                    o_ack_seq           <= 4'(r_expected);
                    o_delivered_payload <= '0;
                    o_delivered_index   <= '0;
                    o_transfer_done     <= !r_active;
                    o_last              <= 1'b1;
                    r_state             <= S_IDLE;
                end
                S_DLV: begin
                    // release one buffered payload from the window base
                    o_valid              <= 1'b1;
                    o_result_kind        <= RK_DATA;
                    o_ack_seq            <= '0;
                    o_delivered_payload  <= 32'(dlv_data);
                    o_delivered_index    <= r_base;
                    o_last               <= !more;
                    r_marks[r_base_slot] <= 1'b0;
                    r_base               <= r_base + 16'd1;
                    r_base_slot          <= next_slot;
                    r_base_seq           <= base_seq_inc;
                    r_fwd                <= 1'b0;
                    r_state              <= more ? S_DLV : S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // results of one packet come back to back, and the last one ends the burst
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !o_valid)
        else $error("result strobe follows a last result");

    a_burst_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid)
        else $error("result burst broken before its last result");

    a_burst_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_busy)
        else $error("not busy while results are still pending");

    a_ack_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result_kind == RK_ACK) |-> ({4'b0000, o_ack_seq} < SEQ_8))
        else $error("ack sequence outside the sequence space");

endmodule

`default_nettype wire

// ----- tb/sv/tb_swarq_check_pkg.sv -----
// Transfer types and the expected-result model for the ARQ receiver bench.
// Depends on swarq_pkg for the item and result kind codes.
`default_nettype none

package tb_swarq_check_pkg;
    import swarq_pkg::*;

    localparam int WIN     = 5;
    localparam int SEQ_MOD = 12;

    // one command as driven on the input ports
    typedef struct {
        logic        kind;
        logic        use_selective;
        logic [15:0] packet_count;
        logic [3:0]  seq;
        logic [31:0] payload;
    } arq_cmd_t;

    // one result as seen on the output ports
    typedef struct {
        logic        result_kind;
        logic [3:0]  ack_seq;
        logic [31:0] payload;
        logic [15:0] index;
        logic        done;
        logic        last;
    } arq_result_t;

    // Tracks receiver state and queues the acks and deliveries each command causes.
    class arq_delivery_model;
        bit          active;
        bit          selective;
        t_completed  completed = CK_NONE;
        bit [3:0]    next_seq;
        bit [15:0]   remaining;
        bit [15:0]   total;
        int unsigned base;
        bit          marks[WIN];
        bit [31:0]   slots[WIN];
        arq_result_t pending[$];
        int unsigned errors;

        function arq_result_t ack_of(logic [3:0] s);
            arq_result_t r;
            r.result_kind = RK_ACK;
            r.ack_seq     = s;
            r.payload     = '0;
            r.index       = '0;
            r.done        = 1'b0;
            r.last        = 1'b0;
            return r;
        endfunction

        function arq_result_t delivery_of(logic [31:0] pay, logic [15:0] idx);
            arq_result_t r;
            r = ack_of(4'd0);
            r.result_kind = RK_DATA;
            r.payload     = pay;
            r.index       = idx;
            return r;
        endfunction

        // Note an accepted command; returns how many results it will cause.
        function int take_command(arq_cmd_t c);
            arq_result_t batch[$];
            int unsigned stop;
            int unsigned hit;
            int unsigned i;
            bit          found;
            int          k;
            if (c.kind == IK_START) begin
                selective = c.use_selective;
                total     = c.packet_count;
                remaining = total;
                next_seq  = 4'd0;
                base      = 0;
                for (k = 0; k < WIN; k++) marks[k] = 1'b0;
                active = (total != 0);
                if (!active) completed = selective ? CK_SEL : CK_GBN;
                return 0;
            end
            if (c.seq >= SEQ_MOD) return 0;
            hit = 0;
            if (!active) begin
                // after completion every packet draws one ack; before any, nothing
                if (completed == CK_NONE) return 0;
                batch.push_back(ack_of(completed == CK_GBN ? next_seq : c.seq));
            end else if (!selective) begin
                // go-back-N: deliver only the in-order packet, always cumulative ack
                if (c.seq == next_seq) begin
                    batch.push_back(delivery_of(c.payload, total - remaining));
                    remaining--;
                    next_seq = 4'((int'(next_seq) + 1) % SEQ_MOD);
                end
                batch.push_back(ack_of(next_seq));
                if (remaining == 0) begin
                    active    = 1'b0;
                    completed = CK_GBN;
                end
            end else begin
                // selective repeat: locate the packet in the window, ack its own seq
                stop  = (base + WIN < total) ? base + WIN : total;
                found = 1'b0;
                for (i = base; i < stop && !found; i++) begin
                    if (i % SEQ_MOD == c.seq) begin
                        found = 1'b1;
                        hit   = i;
                    end
                end
                batch.push_back(ack_of(c.seq));
                if (found) begin
                    // duplicates keep the first payload
                    if (!marks[hit % WIN]) begin
                        marks[hit % WIN] = 1'b1;
                        slots[hit % WIN] = c.payload;
                    end
                    // release the contiguous run from the window base
                    while (base < total && marks[base % WIN]) begin
                        batch.push_back(delivery_of(slots[base % WIN], 16'(base)));
                        marks[base % WIN] = 1'b0;
                        base++;
                    end
                    if (base >= total) begin
                        active    = 1'b0;
                        completed = CK_SEL;
                    end
                end
            end
            for (k = 0; k < batch.size(); k++) begin
                batch[k].done = !active;
                batch[k].last = (k == batch.size() - 1);
                pending.push_back(batch[k]);
            end
            return batch.size();
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Check one result against the oldest expectation.
        function void match_result(arq_result_t got);
            arq_result_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result kind %0d ack %0d payload %h index %0d done %0d last %0d",
                         $time, got.result_kind, got.ack_seq, got.payload, got.index,
                         got.done, got.last);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
            compare_field("ack_seq", 32'(want.ack_seq), 32'(got.ack_seq));
            compare_field("delivered_payload", want.payload, got.payload);
            compare_field("delivered_index", 32'(want.index), 32'(got.index));
            compare_field("transfer_done", 32'(want.done), 32'(got.done));
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

endpackage

`default_nettype wire

// ----- tb/sv/tb_sliding_window_arq_receiver_top.sv -----
// Self-checking bench for the sliding-window ARQ receiver: directed cases, then
// random go-back-N and selective-repeat transfers with random sender gaps.
// Depends on swarq_pkg, tb_swarq_check_pkg and the receiver RTL.
`default_nettype none

module tb_sliding_window_arq_receiver_top;
    import swarq_pkg::*;
    import tb_swarq_check_pkg::*;

    localparam int ITEM_GOAL   = 430;
    localparam int STALL_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic        i_kind;
    logic        i_use_selective;
    logic [15:0] i_packet_count;
    logic [3:0]  i_seq;
    logic [31:0] i_payload;
    logic        o_valid;
    logic        o_result_kind;
    logic [3:0]  o_ack_seq;
    logic [31:0] o_delivered_payload;
    logic [15:0] o_delivered_index;
    logic        o_transfer_done;
    logic        o_last;

    arq_delivery_model sb = new();
    arq_result_t       seen;
    int                counted = 0;
    bit                idle_on = 1'b1;
    int                quiet_cycles = 0;

    sliding_window_arq_receiver_top i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (i_start),
        .o_busy              (o_busy),
        .i_kind              (i_kind),
        .i_use_selective     (i_use_selective),
        .i_packet_count      (i_packet_count),
        .i_seq               (i_seq),
        .i_payload           (i_payload),
        .o_valid             (o_valid),
        .o_result_kind       (o_result_kind),
        .o_ack_seq           (o_ack_seq),
        .o_delivered_payload (o_delivered_payload),
        .o_delivered_index   (o_delivered_index),
        .o_transfer_done     (o_transfer_done),
        .o_last              (o_last)
    );

    always #6 i_clk = ~i_clk;

    // result monitor: every strobed result is checked at the edge that ends it
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            seen.result_kind = o_result_kind;
            seen.ack_seq     = o_ack_seq;
            seen.payload     = o_delivered_payload;
            seen.index       = o_delivered_index;
            seen.done        = o_transfer_done;
            seen.last        = o_last;
            sb.match_result(seen);
        end
    end

    // watchdog: too long without any transfer or result ends the run
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_sliding_window_arq_receiver_top NOT OK");
                $finish;
            end
        end
    end

    function automatic arq_cmd_t make_start(bit sel, logic [15:0] count);
        arq_cmd_t c;
        c.kind          = IK_START;
        c.use_selective = sel;
        c.packet_count  = count;
        c.seq           = 4'($urandom_range(0, 15));
        c.payload       = $urandom;
        return c;
    endfunction

    function automatic arq_cmd_t make_packet(logic [3:0] s, logic [31:0] pay);
        arq_cmd_t c;
        c.kind          = IK_DATA;
        c.use_selective = 1'($urandom_range(0, 1));
        c.packet_count  = 16'($urandom);
        c.seq           = s;
        c.payload       = pay;
        return c;
    endfunction

    // mostly the sequence numbers that move the transfer forward, some noise
    function automatic logic [3:0] pick_seq();
        int unsigned hi;
        if (!sb.active || $urandom_range(0, 99) < 20) return 4'($urandom_range(0, 15));
        if (!sb.selective) return sb.next_seq;
        hi = (sb.base + WIN < sb.total) ? sb.base + WIN : sb.total;
        return 4'($urandom_range(sb.base, hi - 1) % SEQ_MOD);
    endfunction

    // Present one command, with an optional idle gap first, and hold it until taken.
    task automatic send_item(input arq_cmd_t c);
        int gap;
        gap = 0;
        if (idle_on) begin
            while ($urandom_range(0, 99) < 13) gap++;
        end
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start         <= 1'b1;
        i_kind          <= c.kind;
        i_use_selective <= c.use_selective;
        i_packet_count  <= c.packet_count;
        i_seq           <= c.seq;
        i_payload       <= c.payload;
        do @(posedge i_clk); while (o_busy);
        if (sb.take_command(c) != 0 || c.kind == IK_START) counted++;
    endtask

    // sender holds off until every expected result is out
    task automatic hold_until_drained();
        i_start <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
    endtask

    task automatic run_directed();
        // nothing started yet, then an out-of-range sequence
        send_item(make_packet(4'd0, 32'h0000_0000));
        send_item(make_packet(4'd15, 32'hFFFF_FFFF));
        // empty go-back-N transfer completes at once, seq 3 gets ack 0, seq 12 is dropped
        send_item(make_start(1'b0, 16'd0));
        send_item(make_packet(4'd3, $urandom));
        send_item(make_packet(4'd12, $urandom));
        // empty selective transfer: acks carry the packet's own seq
        send_item(make_start(1'b1, 16'd0));
        send_item(make_packet(4'd7, $urandom));
        // go-back-N: out of order, in order, duplicate, completion, after completion
        send_item(make_start(1'b0, 16'd3));
        send_item(make_packet(4'd1, $urandom));
        send_item(make_packet(4'd0, 32'hFFFF_FFFF));
        send_item(make_packet(4'd0, $urandom));
        send_item(make_packet(4'd1, 32'h0000_0000));
        send_item(make_packet(4'd2, 32'hA5A5_5A5A));
        send_item(make_packet(4'd11, $urandom));
        // selective: duplicate keeps first payload, outside window, full-window release
        send_item(make_start(1'b1, 16'd7));
        send_item(make_packet(4'd1, 32'h1111_1111));
        send_item(make_packet(4'd1, 32'h2222_2222));
        send_item(make_packet(4'd9, $urandom));
        send_item(make_packet(4'd4, $urandom));
        send_item(make_packet(4'd3, $urandom));
        send_item(make_packet(4'd2, $urandom));
        send_item(make_packet(4'd0, $urandom));
        send_item(make_packet(4'd6, $urandom));
        send_item(make_packet(4'd5, $urandom));
        // largest count, abandoned by the next start
        send_item(make_start(1'b1, 16'hFFFF));
        send_item(make_packet(4'd0, $urandom));
        send_item(make_start(1'b0, 16'hFFFF));
        send_item(make_packet(4'd0, $urandom));
        hold_until_drained();
    endtask

    task automatic run_random();
        int  pick;
        int  budget;
        int  tail;
        int  n;
        bit  paused;
        logic [15:0] count;
        paused = 1'b0;
        while (counted < ITEM_GOAL) begin
            idle_on = !(counted >= 250 && counted < 330);
            if (!paused && counted >= 200) begin
                hold_until_drained();
                paused = 1'b1;
            end
            // new transfer: mostly short, a few empty or huge
            pick = $urandom_range(0, 99);
            if (pick < 8) count = 16'd0;
            else if (pick < 14) count = 16'($urandom);
            else count = 16'($urandom_range(1, 24));
            send_item(make_start(1'($urandom_range(0, 1)), count));
            budget = 3 * ((count < 20) ? int'(count) : 20) + $urandom_range(1, 6);
            tail   = $urandom_range(0, 3);
            for (n = 0; n < budget && counted < ITEM_GOAL; n++) begin
                if (!sb.active) begin
                    if (tail == 0) break;
                    tail--;
                end
                send_item(make_packet(pick_seq(), $urandom));
            end
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_start         <= 1'b0;
        i_kind          <= IK_DATA;
        i_use_selective <= 1'b0;
        i_packet_count  <= '0;
        i_seq           <= '0;
        i_payload       <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        i_start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb_sliding_window_arq_receiver_top OK");
        end else begin
            $display("tb_sliding_window_arq_receiver_top NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
